>>> sv/ntc_pkg.sv
package ntc_pkg;

	localparam int CHAR_W = 8;
	localparam int KIND_W = 2;
	localparam int FRAC_W = 8;

	typedef enum logic [KIND_W-1:0] {
		KIND_TEXT = 2'd0,
		KIND_INT  = 2'd1,
		KIND_REAL = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [FRAC_W-1:0] frac_digits;
	} ntc_result_t;

	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_EXP_U = 8'h45;
	localparam logic [CHAR_W-1:0] CH_EXP_L = 8'h65;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

endpackage

>>> sv/ntc_scan.sv
module ntc_scan (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic [ntc_pkg::CHAR_W-1:0] char_code,
	input  logic                       last_char,
	output ntc_pkg::ntc_result_t       res
);
	import ntc_pkg::*;

	typedef enum logic [3:0] {
		ST_INIT      = 4'd0,
		ST_SIGN      = 4'd1,
		ST_POINT     = 4'd2,
		ST_INT       = 4'd3,
		ST_FRAC      = 4'd4,
		ST_EXP       = 4'd5,
		ST_INT_END   = 4'd6,
		ST_FRAC_END  = 4'd7,
		ST_EXP_SIGN  = 4'd8,
		ST_EXP_DIG   = 4'd9,
		ST_EXP_END   = 4'd10,
		ST_REJECT    = 4'd11
	} state_t;

	state_t            state_q;
	state_t            state_nx;
	logic [FRAC_W-1:0] count_q;
	logic [FRAC_W-1:0] count_nx;
	logic              is_sign;
	logic              is_exp;
	logic              is_point;
	logic              is_digit;
	logic              is_space;

	assign is_sign  = (char_code == CH_PLUS) || (char_code == CH_MINUS);
	assign is_exp   = (char_code == CH_EXP_U) || (char_code == CH_EXP_L);
	assign is_point = (char_code == CH_POINT);
	assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
	assign is_space = (char_code == CH_SPACE) ||
	                  ((char_code >= CH_TAB) && (char_code <= CH_CR));

	always_comb begin
		state_nx = ST_REJECT;
		unique case (state_q)
			ST_INIT: begin
				if (is_sign) state_nx = ST_SIGN;
				else if (is_point) state_nx = ST_POINT;
				else if (is_digit) state_nx = ST_INT;
				else if (is_space) state_nx = ST_INIT;
			end
			ST_SIGN: begin
				if (is_point) state_nx = ST_POINT;
				else if (is_digit) state_nx = ST_INT;
			end
			ST_POINT: begin
				if (is_digit) state_nx = ST_FRAC;
			end
			ST_INT: begin
				if (is_exp) state_nx = ST_EXP;
				else if (is_point) state_nx = ST_FRAC;
				else if (is_digit) state_nx = ST_INT;
				else if (is_space) state_nx = ST_INT_END;
			end
			ST_FRAC: begin
				if (is_exp) state_nx = ST_EXP;
				else if (is_digit) state_nx = ST_FRAC;
				else if (is_space) state_nx = ST_FRAC_END;
			end
			ST_EXP: begin
				if (is_sign) state_nx = ST_EXP_SIGN;
				else if (is_digit) state_nx = ST_EXP_DIG;
			end
			ST_INT_END: begin
				if (is_space) state_nx = ST_INT_END;
			end
			ST_FRAC_END: begin
				if (is_space) state_nx = ST_FRAC_END;
			end
			ST_EXP_SIGN: begin
				if (is_digit) state_nx = ST_EXP_DIG;
			end
			ST_EXP_DIG: begin
				if (is_digit) state_nx = ST_EXP_DIG;
				else if (is_space) state_nx = ST_EXP_END;
			end
			ST_EXP_END: begin
				if (is_space) state_nx = ST_EXP_END;
			end
			default: state_nx = ST_REJECT;
		endcase
	end

	assign count_nx = ((state_nx == ST_FRAC) && is_digit && (count_q != {FRAC_W{1'b1}})) ?
	                  count_q + 1'b1 : count_q;

	always_comb begin
		res.kind        = KIND_TEXT;
		res.frac_digits = '0;
		unique case (state_nx)
			ST_INT, ST_INT_END: res.kind = KIND_INT;
			ST_FRAC, ST_FRAC_END, ST_EXP_DIG, ST_EXP_END: begin
				res.kind        = KIND_REAL;
				res.frac_digits = count_nx;
			end
			default: res.kind = KIND_TEXT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			count_q <= '0;
		end else if (step) begin
			if (last_char) begin
				state_q <= ST_INIT;
				count_q <= '0;
			end else begin
				state_q <= state_nx;
				count_q <= count_nx;
			end
		end
	end

endmodule

>>> sv/numeric_token_classifier.sv
// A token's last character passes the input stage, then its result is registered in the output register and offered.
// Throughput: one character per cycle; in_ready drops only while a finished
// result waits in the output register and the next staged character also ends a token.
// Reset (arst_n low, asynchronous): recognizer to initial state, fraction count
// to zero, input and output stages empty.
module numeric_token_classifier (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [ntc_pkg::CHAR_W-1:0] char_code,
	input  logic                       last_char,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [ntc_pkg::KIND_W-1:0] kind,
	output logic [ntc_pkg::FRAC_W-1:0] frac_digits
);
	import ntc_pkg::*;

	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              last_s1;
	logic              step;
	logic              out_valid_q;
	ntc_result_t       res;
	ntc_result_t       res_q;

	// a staged token end may move only when the output slot is free or freeing
	assign step     = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_code;
			last_s1 <= last_char;
		end
	end

	ntc_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.char_code (char_s1),
		.last_char (last_s1),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			res_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = res_q.kind;
	assign frac_digits = res_q.frac_digits;

endmodule

>>> sv/ntc_checker.sv
module ntc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [ntc_pkg::KIND_W-1:0] kind,
	input logic [ntc_pkg::FRAC_W-1:0] frac_digits
);
	import ntc_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(frac_digits))
		else $error("result request dropped or changed while stalled");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (kind == KIND_TEXT) || (kind == KIND_INT) || (kind == KIND_REAL))
		else $error("illegal kind code");

	a_frac_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind != KIND_REAL) |-> frac_digits == '0)
		else $error("fraction count nonzero for non-real token");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");

endmodule

bind numeric_token_classifier ntc_checker u_ntc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.kind        (kind),
	.frac_digits (frac_digits)
);

>>> dv/numeric_token_classifier_test.sv
`timescale 1ns / 1ps

module numeric_token_classifier_test;
	import ntc_pkg::*;

	localparam int RAND_ITEMS  = 1300;
	localparam int CYCLE_LIMIT = 500000;

	typedef enum logic [3:0] {
		S_INIT, S_SIGN, S_POINT, S_INT, S_FRAC, S_EXP,
		S_INT_END, S_FRAC_END, S_EXP_SIGN, S_EXP_DIG, S_EXP_END, S_REJECT
	} scan_t;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              ends;
		logic              pinned;
		kind_t             exp_kind;
		logic [FRAC_W-1:0] exp_frac;
	} dir_row_t;

	localparam dir_row_t DIR_TAB [24] = '{
		{"7",      1'b1, 1'b1, KIND_INT,  8'd0},
		{CH_SPACE, 1'b0, 1'b0, KIND_TEXT, 8'd0},
		{CH_PLUS,  1'b0, 1'b0, KIND_TEXT, 8'd0},
		{CH_POINT, 1'b0, 1'b0, KIND_TEXT, 8'd0},
		{"5",      1'b0, 1'b0, KIND_TEXT, 8'd0},
		{CH_SPACE, 1'b1, 1'b0, KIND_TEXT, 8'd0},
		{"1",      1'b0, 1'b0, KIND_TEXT, 8'd0},
		{CH_POINT, 1'b0, 1'b0, KIND_TEXT, 8'd0},
		{CH_EXP_U, 1'b0, 1'b0, KIND_TEXT, 8'd0},
		{CH_MINUS, 1'b0, 1'b0, KIND_TEXT, 8'd0},
		{"9",      1'b1, 1'b0, KIND_TEXT, 8'd0},
		{"2",      1'b0, 1'b0, KIND_TEXT, 8'd0},
		{CH_EXP_L, 1'b0, 1'b0, KIND_TEXT, 8'd0},
		{"5",      1'b1, 1'b0, KIND_TEXT, 8'd0},
		{8'hFF,    1'b1, 1'b1, KIND_TEXT, 8'd0},
		{8'h00,    1'b0, 1'b0, KIND_TEXT, 8'd0},
		{"1",      1'b1, 1'b1, KIND_TEXT, 8'd0},
		{CH_TAB,   1'b0, 1'b0, KIND_TEXT, 8'd0},
		{"9",      1'b0, 1'b0, KIND_TEXT, 8'd0},
		{CH_CR,    1'b1, 1'b0, KIND_TEXT, 8'd0},
		{CH_POINT, 1'b1, 1'b1, KIND_TEXT, 8'd0},
		{CH_MINUS, 1'b1, 1'b1, KIND_TEXT, 8'd0},
		{"1",      1'b0, 1'b0, KIND_TEXT, 8'd0},
		{CH_EXP_U, 1'b1, 1'b0, KIND_TEXT, 8'd0}
	};

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [CHAR_W-1:0] char_code;
	logic              last_char;
	logic              out_valid;
	logic              out_ready;
	logic [KIND_W-1:0] kind;
	logic [FRAC_W-1:0] frac_digits;

	logic        cur_pinned;
	ntc_result_t cur_pinned_res;

	scan_t             scan_st = S_INIT;
	logic [FRAC_W-1:0] frac_cnt = '0;
	ntc_result_t       class_q [$];
	logic [CHAR_W-1:0] tok_q [$];

	int  mismatches = 0;
	int  cycle_cnt = 0;
	int  chars_sent = 0;
	bit  tx_idle_on = 1'b1;
	bit  rx_idle_on = 1'b1;

	numeric_token_classifier dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.char_code   (char_code),
		.last_char   (last_char),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.frac_digits (frac_digits)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic scan_t next_scan(scan_t s, logic [CHAR_W-1:0] c);
		bit    digit;
		bit    space;
		scan_t ns;
		digit = c >= CH_ZERO && c <= CH_NINE;
		space = c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
		ns = S_REJECT;
		if (s > S_EXP_END) begin
			ns = S_REJECT;
		end else if (c == CH_PLUS || c == CH_MINUS) begin
			if (s == S_INIT) ns = S_SIGN;
			else if (s == S_EXP) ns = S_EXP_SIGN;
		end else if (c == CH_EXP_U || c == CH_EXP_L) begin
			if (s == S_INT || s == S_FRAC) ns = S_EXP;
		end else if (c == CH_POINT) begin
			if (s == S_INIT || s == S_SIGN) ns = S_POINT;
			else if (s == S_INT) ns = S_FRAC;
		end else if (digit) begin
			case (s)
				S_INIT, S_SIGN, S_INT: ns = S_INT;
				S_POINT, S_FRAC: ns = S_FRAC;
				S_EXP, S_EXP_SIGN, S_EXP_DIG: ns = S_EXP_DIG;
				default: ns = S_REJECT;
			endcase
		end else if (space) begin
			case (s)
				S_INIT: ns = S_INIT;
				S_INT, S_INT_END: ns = S_INT_END;
				S_FRAC, S_FRAC_END: ns = S_FRAC_END;
				S_EXP_DIG, S_EXP_END: ns = S_EXP_END;
				default: ns = S_REJECT;
			endcase
		end
		return ns;
	endfunction

	task automatic classify_char(input logic [CHAR_W-1:0] c, input logic ends,
			output bit done, output ntc_result_t res);
		scan_t ns;
		ns = next_scan(scan_st, c);
		if (ns == S_FRAC && c >= CH_ZERO && c <= CH_NINE && frac_cnt != 8'hFF)
			frac_cnt++;
		scan_st = ns;
		done = ends;
		res.kind = KIND_TEXT;
		res.frac_digits = '0;
		if (ends) begin
			case (ns)
				S_INT, S_INT_END: res.kind = KIND_INT;
				S_FRAC, S_FRAC_END, S_EXP_DIG, S_EXP_END: begin
					res.kind = KIND_REAL;
					res.frac_digits = frac_cnt;
				end
				default: ;
			endcase
			scan_st = S_INIT;
			frac_cnt = '0;
		end
	endtask

	task automatic note_mismatch(input string what, input int want, input int got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
	endtask

	always @(posedge clk) begin : monitor
		bit          done;
		ntc_result_t res;
		ntc_result_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				classify_char(char_code, last_char, done, res);
				if (done)
					class_q.push_back(cur_pinned ? cur_pinned_res : res);
			end
			if (out_valid && out_ready) begin
				if (class_q.size() == 0) begin
					note_mismatch("result with no token pending", -1, kind);
				end else begin
					want = class_q.pop_front();
					if (kind !== want.kind)
						note_mismatch("kind", want.kind, kind);
					if (frac_digits !== want.frac_digits)
						note_mismatch("frac_digits", want.frac_digits, frac_digits);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("numeric_token_classifier: mismatch");
			$finish;
		end
	end

	function automatic logic [CHAR_W-1:0] pick_digit();
		return CH_ZERO + CHAR_W'($urandom_range(0, 9));
	endfunction

	function automatic logic [CHAR_W-1:0] pick_space();
		int k;
		k = $urandom_range(0, 5);
		return (k == 5) ? CH_SPACE : CH_TAB + CHAR_W'(k);
	endfunction

	function automatic logic [CHAR_W-1:0] pick_sign();
		return $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
	endfunction

	task automatic build_number(input int frac_lo, input int frac_hi);
		tok_q.delete();
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 2)) tok_q.push_back(pick_space());
		if ($urandom_range(0, 2) == 0)
			tok_q.push_back(pick_sign());
		repeat ($urandom_range(0, 4)) tok_q.push_back(pick_digit());
		if (frac_lo > 0 || $urandom_range(0, 1)) begin
			tok_q.push_back(CH_POINT);
			repeat ($urandom_range(frac_lo, frac_hi)) tok_q.push_back(pick_digit());
		end
		if ($urandom_range(0, 2) == 0) begin
			tok_q.push_back($urandom_range(0, 1) ? CH_EXP_U : CH_EXP_L);
			if ($urandom_range(0, 1))
				tok_q.push_back(pick_sign());
			repeat ($urandom_range(0, 3)) tok_q.push_back(pick_digit());
		end
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 2)) tok_q.push_back(pick_space());
		if (tok_q.size() == 0)
			tok_q.push_back(pick_digit());
		if ($urandom_range(0, 5) == 0)
			tok_q[$urandom_range(0, tok_q.size() - 1)] = CHAR_W'($urandom_range(0, 255));
	endtask

	task automatic send_char(input logic [CHAR_W-1:0] c, input logic ends,
			input logic pinned, input ntc_result_t pinned_res);
		int gap;
		if ($urandom_range(0, 63) == 0)
			tx_idle_on = !tx_idle_on;
		gap = tx_idle_on ? $urandom_range(0, 15) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		char_code      <= c;
		last_char      <= ends;
		cur_pinned     <= pinned;
		cur_pinned_res <= pinned_res;
		in_valid       <= 1'b1;
		do @(posedge clk); while (!(in_valid && in_ready));
		@(negedge clk);
	endtask

	task automatic send_token();
		foreach (tok_q[i])
			send_char(tok_q[i], i == tok_q.size() - 1, 1'b0, '0);
		chars_sent += tok_q.size();
	endtask

	initial begin : receiver
		int stall;
		int results_done;
		bit held;
		results_done = 0;
		held = 1'b0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 63) == 0)
				rx_idle_on = !rx_idle_on;
			stall = rx_idle_on ? $urandom_range(0, 15) : 0;
			// long stall on result requests so the input side backs up
			if (results_done == 30 && !held) begin
				stall = 400;
				held = 1'b1;
			end
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
			results_done++;
			@(negedge clk);
		end
	end

	initial begin : sender
		int long_left;
		int n;
		arst_n = 1'b0;
		in_valid = 1'b0;
		char_code = '0;
		last_char = 1'b0;
		cur_pinned = 1'b0;
		cur_pinned_res = '0;
		long_left = 2;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (DIR_TAB[i])
			send_char(DIR_TAB[i].ch, DIR_TAB[i].ends, DIR_TAB[i].pinned,
				{DIR_TAB[i].exp_kind, DIR_TAB[i].exp_frac});

		while (chars_sent < RAND_ITEMS) begin
			if (long_left != 0 && chars_sent > 400) begin
				// fraction count right at and past saturation
				if (long_left == 2) build_number(255, 255);
				else build_number(256, 300);
				long_left--;
			end else if ($urandom_range(0, 7) == 0) begin
				tok_q.delete();
				n = $urandom_range(1, 6);
				repeat (n) begin
					case ($urandom_range(0, 4))
						0: tok_q.push_back(pick_digit());
						1: tok_q.push_back(pick_sign());
						2: tok_q.push_back($urandom_range(0, 1) ? CH_POINT : CH_EXP_L);
						3: tok_q.push_back(pick_space());
						default: tok_q.push_back(CHAR_W'($urandom_range(0, 255)));
					endcase
				end
			end else begin
				build_number(0, 5);
			end
			send_token();
		end
		in_valid <= 1'b0;

		while (class_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("numeric_token_classifier: match");
		else
			$display("numeric_token_classifier: mismatch");
		$finish;
	end

endmodule
